// ----- rtl/free_block_bitmap_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// free block bitmap allocator assertion macros
// concurrent check helpers used by the allocator top level
// ----------------------------------------------------------------------------
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FBBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbba assertion failed");

// next-cycle implication
`define FBBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbba assertion failed");

`endif

// ----- rtl/fbba_pkg.sv -----
// ----------------------------------------------------------------------------
// fbba_pkg
// shared widths, codes and types of the free block bitmap allocator
// ----------------------------------------------------------------------------
package fbba_pkg;

  localparam int IDX_W           = 10;
  localparam int ACT_W           = 2;
  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int WORD_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH     = 2;

  // action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MARK    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  // classified operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bk_stat_t;

endpackage

// ----- rtl/fbba_in_if.sv -----
// ----------------------------------------------------------------------------
// fbba_in_if
// request channel: action and block index with valid/ready
// ----------------------------------------------------------------------------
interface fbba_in_if;

  logic                        valid;
  logic                        ready;
  logic [fbba_pkg::ACT_W-1:0]  action;
  logic [fbba_pkg::IDX_W-1:0]  block_index;

  modport source (output valid, output action, output block_index, input ready);
  modport sink (input valid, input action, input block_index, output ready);

endinterface

// ----- rtl/fbba_out_if.sv -----
// ----------------------------------------------------------------------------
// fbba_out_if
// result channel: block number and status with valid/ready
// ----------------------------------------------------------------------------
interface fbba_out_if;

  logic                        valid;
  logic                        ready;
  logic [fbba_pkg::IDX_W-1:0]  block_number;
  logic                        status;

  modport source (output valid, output block_number, output status, input ready);
  modport sink (input valid, input block_number, input status, output ready);

endinterface

// ----- rtl/fbba_front.sv -----
// ----------------------------------------------------------------------------
// fbba_front
// accepts requests, range checks the index and splits it into map word
// ----------------------------------------------------------------------------
module fbba_front #(
  parameter int NUM_BLOCKS = fbba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = fbba_pkg::WORD_BITS_DEF
) (
  fbba_in_if.sink          in_if,
  input  logic             q_full,
  output logic             push,
  output fbba_pkg::cmd_t   cmd
);

  localparam int IDX_W    = fbba_pkg::IDX_W;
  localparam int RECIP_SH = 17;
  localparam int RECIP    = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = IDX_W + RECIP_W;
  localparam int CMP_W    = 18;

  logic [PROD_W-1:0] prod;
  logic              in_range;

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  // index / word_bits by reciprocal, exact for ten bit indexes
  assign prod     = PROD_W'(in_if.block_index) * PROD_W'(RECIP);
  assign in_range = CMP_W'(in_if.block_index) < CMP_W'(NUM_BLOCKS);

  always_comb begin
    cmd.idx  = in_if.block_index;
    cmd.word = prod[RECIP_SH +: IDX_W];
    case (in_if.action)
      fbba_pkg::ACT_ALLOC:   cmd.op = fbba_pkg::OP_ALLOC;
      fbba_pkg::ACT_MARK:    cmd.op = in_range ? fbba_pkg::OP_MARK : fbba_pkg::OP_NOP;
      fbba_pkg::ACT_RELEASE: cmd.op = in_range ? fbba_pkg::OP_RELEASE : fbba_pkg::OP_NOP;
      default:               cmd.op = fbba_pkg::OP_NOP;
    endcase
  end

endmodule

// ----- rtl/fbba_queue.sv -----
// ----------------------------------------------------------------------------
// fbba_queue
// short command queue decoupling request intake from map update
// ----------------------------------------------------------------------------
module fbba_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fbba_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output fbba_pkg::cmd_t    head_cmd,
  output fbba_pkg::q_stat_t stat
);

  localparam int DEPTH = fbba_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fbba_pkg::cmd_t   entry_r [DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = count_r == CNT_W'(DEPTH);
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/fbba_back.sv -----
// ----------------------------------------------------------------------------
// fbba_back
// map word read-modify-write, first-fit search and result register
// ----------------------------------------------------------------------------
module fbba_back #(
  parameter int NUM_BLOCKS = fbba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = fbba_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fbba_pkg::cmd_t     q_cmd,
  input  logic               q_empty,
  output logic               pop,
  fbba_out_if.source         out_if,
  output fbba_pkg::bk_stat_t stat
);

  localparam int IDX_W     = fbba_pkg::IDX_W;
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int MUL_W     = IDX_W + BIT_W + 1;
  localparam int NB_W      = WADDR_W + BIT_W + 1;
  localparam int TAIL      = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] FULL_MASK = '1;
  localparam logic [WORD_BITS-1:0] LAST_MASK = FULL_MASK >> (WORD_BITS - TAIL);
  localparam logic [WADDR_W-1:0]   LAST_WORD = WADDR_W'(MAP_WORDS - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WR   = 1'b1;

  function automatic logic [WADDR_W-1:0] first_word(input logic [MAP_WORDS-1:0] v);
    logic [WADDR_W-1:0] r;
    r = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WADDR_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  logic                 state_r, state_nxt;
  logic [MAP_WORDS-1:0] written_r, written_nxt;
  logic [MAP_WORDS-1:0] nonempty_r, nonempty_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_num_r;
  logic                 out_status_r;

  fbba_pkg::cmd_t       cur_r;
  logic [WADDR_W-1:0]   addr_r;
  logic [BIT_W-1:0]     bit_r;
  logic                 any_r;
  logic                 hit_r;
  logic [WORD_BITS-1:0] rdata_r;

  logic [WADDR_W-1:0]   rd_addr;
  logic [MUL_W-1:0]     base;
  logic [MUL_W-1:0]     rem;
  logic [WORD_BITS-1:0] cur_word;
  logic [BIT_W-1:0]     alloc_bit;
  logic [NB_W-1:0]      alloc_num;
  logic [WORD_BITS-1:0] new_word;
  logic                 wr_en;
  logic [IDX_W-1:0]     res_num;
  logic                 res_status;
  logic                 fin;

  assign pop     = (state_r == S_IDLE) && !q_empty;
  assign rd_addr = (q_cmd.op == fbba_pkg::OP_ALLOC) ? first_word(nonempty_r)
                                                     : WADDR_W'(q_cmd.word);
  assign base    = MUL_W'(q_cmd.word) * MUL_W'(WORD_BITS);
  assign rem     = MUL_W'(q_cmd.idx) - base;

  // words never written read as their reset pattern, all blocks free
  assign cur_word  = hit_r ? rdata_r : ((addr_r == LAST_WORD) ? LAST_MASK : FULL_MASK);
  assign alloc_bit = first_bit(cur_word);
  assign alloc_num = NB_W'(addr_r) * NB_W'(WORD_BITS) + NB_W'(alloc_bit);
  assign fin       = (state_r == S_WR) && (!out_valid_r || out_if.ready);

  always_comb begin
    new_word   = cur_word;
    wr_en      = 1'b0;
    res_num    = cur_r.idx;
    res_status = 1'b0;
    case (cur_r.op)
      fbba_pkg::OP_ALLOC: begin
        if (any_r) begin
          new_word = cur_word & ~(WORD_BITS'(1) << alloc_bit);
          wr_en    = 1'b1;
          res_num  = IDX_W'(alloc_num);
        end else begin
          res_num    = '0;
          res_status = 1'b1;
        end
      end
      fbba_pkg::OP_MARK: begin
        new_word = cur_word & ~(WORD_BITS'(1) << bit_r);
        wr_en    = 1'b1;
      end
      fbba_pkg::OP_RELEASE: begin
        new_word = cur_word | (WORD_BITS'(1) << bit_r);
        wr_en    = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    written_nxt   = written_r;
    nonempty_nxt  = nonempty_r;
    out_valid_nxt = out_valid_r;
    if (out_if.ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (pop) state_nxt = S_WR;
      end
      S_WR: begin
        if (fin) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (wr_en) begin
            written_nxt[addr_r]  = 1'b1;
            nonempty_nxt[addr_r] = |new_word;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      written_r   <= '0;
      nonempty_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      written_r   <= written_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r   <= q_cmd;
      addr_r  <= rd_addr;
      bit_r   <= rem[BIT_W-1:0];
      any_r   <= |nonempty_r;
      hit_r   <= written_r[rd_addr];
      rdata_r <= mem[rd_addr];
    end
    if (fin) begin
      out_num_r    <= res_num;
      out_status_r <= res_status;
      if (wr_en) begin
        mem[addr_r] <= new_word;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.block_number = out_num_r;
  assign out_if.status       = out_status_r;

  assign stat.busy = state_r == S_WR;
  assign stat.done = fin;

endmodule

// ----- rtl/free_block_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator
// first-fit free block allocator over a one-bit-per-block map
// ----------------------------------------------------------------------------
// requests enter on in_if (action, block_index) with valid/ready; each
// transaction yields exactly one result on out_if (block_number, status)
// allocate returns the lowest free block and marks it used, status 1 and
// block 0 when the map is full; mark-used and release echo the index
// a request passes through the command queue, the map word read registers
// and the result register; the update unit takes one command at a time,
// its map word read followed by its write-back, before it takes the next
// a two-entry command queue keeps in_if ready while the update unit or the
// result register is busy; a stalled out_if holds its result and the queue
// fills, after which in_if.ready drops
// reset (rst_n low, synchronous) marks every block free at once through
// per-word written flags; the map is usable in the first cycle after reset
// ----------------------------------------------------------------------------
`include "free_block_bitmap_allocator_macros.svh"

module free_block_bitmap_allocator #(
  parameter int NUM_BLOCKS = fbba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = fbba_pkg::WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fbba_in_if.sink    in_if,
  fbba_out_if.source out_if
);

  fbba_pkg::cmd_t     push_cmd;
  fbba_pkg::cmd_t     head_cmd;
  fbba_pkg::q_stat_t  q_stat;
  fbba_pkg::bk_stat_t bk_stat;
  logic               push;
  logic               pop;

  fbba_front #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_front (
    .in_if  (in_if),
    .q_full (q_stat.full),
    .push   (push),
    .cmd    (push_cmd)
  );

  fbba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  fbba_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (head_cmd),
    .q_empty (q_stat.empty),
    .pop     (pop),
    .out_if  (out_if),
    .stat    (bk_stat)
  );

  `FBBA_ASSERT_NEXT(a_accept_queued, clk, rst_n, in_if.valid && in_if.ready, !q_stat.empty)
  `FBBA_ASSERT_IMPL(a_result_from_update, clk, rst_n, $rose(out_if.valid), $past(bk_stat.done))
  `FBBA_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_if.valid && out_if.status, out_if.block_number == '0)
  `FBBA_ASSERT_IMPL(a_pop_idle, clk, rst_n, pop, !bk_stat.busy && !q_stat.empty)

endmodule
